/* rtl/single_freq_phasor_accumulator_defines.svh */
// Assertion macros for the single-frequency phasor accumulator.
// Included by the RTL file that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef SINGLE_FREQ_PHASOR_ACCUMULATOR_DEFINES_SVH
`define SINGLE_FREQ_PHASOR_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define SFPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfpa assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfpa assertion failed");
`else
`define SFPA_ASSERT_IMP(label, ante, cons)
`define SFPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/sfpa_pkg.sv */
// Shared types, constants and arithmetic helpers of the phasor accumulator.
// No dependencies; imported by every module of the block.
package sfpa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [1:0] CFG_DT_SCALE   = 2'd1;

    localparam logic [31:0] PHASE_STEP_RESET = 32'd0;
    localparam logic [15:0] DT_SCALE_RESET   = 16'd32768;

    localparam int QUEUE_DEPTH   = 4;
    localparam int CORDIC_STAGES = 16;

    // Gain-compensated CORDIC start value, 2^30 scale.
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        logic               slot_ok;
        logic [8:0]         slot;
        logic [31:0]        phase;
        logic signed [16:0] scaled;
    } queue_entry_t;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    function automatic logic signed [32:0] sfpa_atan(input logic [3:0] idx);
        logic signed [32:0] r;
        begin
            case (idx)
                4'd0:    r = 33'sh0_2000_0000;
                4'd1:    r = 33'sh0_12E4_051E;
                4'd2:    r = 33'sh0_09FB_385B;
                4'd3:    r = 33'sh0_0511_11D4;
                4'd4:    r = 33'sh0_028B_0D43;
                4'd5:    r = 33'sh0_0145_D7E1;
                4'd6:    r = 33'sh0_00A2_F61E;
                4'd7:    r = 33'sh0_0051_7C55;
                4'd8:    r = 33'sh0_0028_BE53;
                4'd9:    r = 33'sh0_0014_5F2F;
                4'd10:   r = 33'sh0_000A_2F98;
                4'd11:   r = 33'sh0_0005_17CC;
                4'd12:   r = 33'sh0_0002_8BE6;
                4'd13:   r = 33'sh0_0001_45F3;
                4'd14:   r = 33'sh0_0000_A2FA;
                4'd15:   r = 33'sh0_0000_517D;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Rounds a 2^30-scaled value to Q1.15 and clips it to 16 bits.
    function automatic logic signed [15:0] sfpa_to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [18:0] r;
        logic signed [15:0] q;
        begin
            t = {v[32], v} + 34'sd16384;
            r = t[33:15];
            if (r > 19'sd32767)
                q = 16'sh7FFF;
            else if (r < -19'sd32768)
                q = 16'sh8000;
            else
                q = r[15:0];
            return q;
        end
    endfunction

endpackage

/* rtl/single_freq_phasor_accumulator.sv */
// Running single-bin DFT accumulator. After reset the block clears its POINTS
// accumulator entries, one per cycle, and takes no input item until the clear
// is done; configuration writes are taken at any time. Each accepted item then
// takes a fetch, sixteen CORDIC iterations on the one shared rotator, a round,
// a multiply and an accumulate that waits while the result register is unread;
// an out-of-array slot goes from the fetch straight to the accumulate. The
// rotator sets the sustained rate; a four-entry queue in front of it and the
// result register behind it let the input and output sides stall independently.
module single_freq_phasor_accumulator
    import sfpa_pkg::*;
#(
    parameter int POINTS     = 512,
    parameter int ANGLE_BITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [8:0]         slot,
    input  logic [23:0]        step_index,
    input  logic signed [15:0] field_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] acc_real,
    output logic signed [47:0] acc_imag,
    output logic               saturated
);

    logic         push;
    queue_entry_t push_data;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    queue_entry_t q_head;
    logic         clear_busy;

    sfpa_front #(
        .POINTS (POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .slot         (slot),
        .step_index   (step_index),
        .field_sample (field_sample),
        .q_full       (q_full),
        .clear_busy   (clear_busy),
        .push         (push),
        .push_data    (push_data)
    );

    sfpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sfpa_back #(
        .POINTS     (POINTS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .acc_real   (acc_real),
        .acc_imag   (acc_imag),
        .saturated  (saturated)
    );

endmodule

/* rtl/sfpa_queue.sv */
// Short queue of classified items between the front end and the back end.
// Depends on sfpa_pkg for the entry type and depth.
module sfpa_queue
    import sfpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output queue_entry_t head,
    output logic         empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] DEPTH_COUNT = (PW + 1)'(QUEUE_DEPTH);

    queue_entry_t  entries [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    assign head  = entries[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == DEPTH_COUNT);

endmodule

/* rtl/sfpa_front.sv */
// Front end: configuration registers, input transfer, phase and sample scaling.
// Depends on sfpa_pkg; feeds sfpa_queue.
module sfpa_front
    import sfpa_pkg::*;
#(
    parameter int POINTS = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [8:0]         slot,
    input  logic [23:0]        step_index,
    input  logic signed [15:0] field_sample,
    input  logic               q_full,
    input  logic               clear_busy,
    output logic               push,
    output queue_entry_t       push_data
);

    logic [31:0]        phase_step_reg, phase_step_next;
    logic [15:0]        dt_scale_reg,   dt_scale_next;
    logic [55:0]        phase_prod;
    logic signed [32:0] scale_prod;

    always_comb
    begin
        phase_step_next = phase_step_reg;
        dt_scale_next   = dt_scale_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: phase_step_next = cfg_data;
                CFG_DT_SCALE:   dt_scale_next   = cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            dt_scale_reg   <= DT_SCALE_RESET;
        end
        else
        begin
            phase_step_reg <= phase_step_next;
            dt_scale_reg   <= dt_scale_next;
        end
    end

    // Only the low 32 bits of the phase matter: it wraps once per turn.
    assign phase_prod = phase_step_reg * step_index;
    assign scale_prod = field_sample * $signed({1'b0, dt_scale_reg});

    assign in_ready = !q_full && !clear_busy;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_data.slot_ok = ({23'd0, slot} < 32'(POINTS));
        push_data.slot    = slot;
        push_data.phase   = phase_prod[31:0];
        push_data.scaled  = scale_prod[32:16];
    end

endmodule

/* rtl/sfpa_back.sv */
// Back end: shared CORDIC rotator, complex multiply and saturating accumulation
// into the slot memory, plus the result register. Depends on sfpa_pkg.
`include "single_freq_phasor_accumulator_defines.svh"

module sfpa_back
    import sfpa_pkg::*;
#(
    parameter int POINTS     = 512,
    parameter int ANGLE_BITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  queue_entry_t       q_head,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] acc_real,
    output logic signed [47:0] acc_imag,
    output logic               saturated
);

    localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int IW = $clog2(CORDIC_STAGES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POINTS - 1);
    localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STAGES - 1);
    localparam logic [31:0]   ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT,
        ST_CONV,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [IW-1:0]      iter_reg, iter_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [47:0] acc_real_reg, acc_real_next;
    logic signed [47:0] acc_imag_reg, acc_imag_next;
    logic               saturated_reg, saturated_next;

    // Per-item working registers.
    logic               slot_ok_reg;
    logic [AW-1:0]      addr_reg;
    logic [1:0]         quad_reg;
    logic signed [16:0] scaled_reg;
    logic signed [32:0] x_reg, x_next;
    logic signed [32:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [32:0] prod_re_reg, prod_im_reg;
    logic [95:0]        rd_data_reg;

    logic [95:0]        mem [POINTS];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [95:0]        mem_wdata;

    logic [12:0]        slot_wide;
    logic [AW-1:0]      head_addr;
    logic [31:0]        head_angle;
    logic               out_free;
    logic               acc_go;
    logic signed [32:0] dx, dy, xc, yc;
    logic signed [32:0] mul_re, mul_im;
    logic signed [47:0] old_re, old_im;
    logic signed [48:0] sum_re, sum_im;
    logic signed [47:0] new_re, new_im;
    logic               clip_re, clip_im;

    assign slot_wide  = {4'd0, q_head.slot};
    assign head_addr  = slot_wide[AW-1:0];
    assign head_angle = q_head.phase & ANGLE_MASK;
    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign acc_go     = (state_reg == ST_ACC) && out_free;

    // One CORDIC micro-rotation per cycle; the shift amount is the iteration count.
    always_comb
    begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        if (!z_reg[32])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - sfpa_atan(iter_reg);
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + sfpa_atan(iter_reg);
        end
    end

    // Quadrant fold-back after the rotator has covered the first quadrant.
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                xc = x_reg;
                yc = y_reg;
            end
            2'd1:
            begin
                xc = -y_reg;
                yc = x_reg;
            end
            2'd2:
            begin
                xc = -x_reg;
                yc = -y_reg;
            end
            default:
            begin
                xc = y_reg;
                yc = -x_reg;
            end
        endcase
    end

    assign mul_re = scaled_reg * cos_reg;
    assign mul_im = scaled_reg * sin_reg;

    always_comb
    begin
        old_re  = rd_data_reg[95:48];
        old_im  = rd_data_reg[47:0];
        sum_re  = {old_re[47], old_re} + {{16{prod_re_reg[32]}}, prod_re_reg};
        sum_im  = {old_im[47], old_im} + {{16{prod_im_reg[32]}}, prod_im_reg};
        clip_re = (sum_re[48] != sum_re[47]);
        clip_im = (sum_im[48] != sum_im[47]);
        if (clip_re)
            new_re = sum_re[48] ? ACC_MIN : ACC_MAX;
        else
            new_re = sum_re[47:0];
        if (clip_im)
            new_im = sum_im[48] ? ACC_MIN : ACC_MAX;
        else
            new_im = sum_im[47:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        acc_real_next  = acc_real_reg;
        acc_imag_next  = acc_imag_reg;
        saturated_next = saturated_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                iter_next = '0;
                if (!q_empty)
                    state_next = q_head.slot_ok ? ST_ROT : ST_ACC;
            end
            ST_ROT:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                    state_next = ST_CONV;
            end
            ST_CONV:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    // An out-of-range slot leaves the memory alone and reports zero.
                    acc_real_next  = slot_ok_reg ? new_re : '0;
                    acc_imag_next  = slot_ok_reg ? new_im : '0;
                    saturated_next = slot_ok_reg && (clip_re || clip_im);
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            acc_real_reg  <= '0;
            acc_imag_reg  <= '0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            acc_real_reg  <= acc_real_next;
            acc_imag_reg  <= acc_imag_next;
            saturated_reg <= saturated_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            slot_ok_reg <= q_head.slot_ok;
            addr_reg    <= head_addr;
            quad_reg    <= head_angle[31:30];
            scaled_reg  <= q_head.scaled;
            x_reg       <= CORDIC_X0;
            y_reg       <= '0;
            z_reg       <= {3'b000, head_angle[29:0]};
        end
        else if (state_reg == ST_ROT)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (state_reg == ST_CONV)
        begin
            cos_reg <= sfpa_to_q15(xc);
            sin_reg <= sfpa_to_q15(yc);
        end
        if (state_reg == ST_MUL)
        begin
            prod_re_reg <= mul_re;
            prod_im_reg <= -mul_im;
        end
    end

    // The slot memory is read when an item is taken and written when its result
    // is produced; items are handled one at a time, so no forwarding is needed.
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || (acc_go && slot_ok_reg);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? 96'd0 : {new_re, new_im};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (q_pop)
            rd_data_reg <= mem[head_addr];
    end

    assign clear_busy = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign acc_real   = acc_real_reg;
    assign acc_imag   = acc_imag_reg;
    assign saturated  = saturated_reg;

    `SFPA_ASSERT_IMP(a_no_result_in_clear, state_reg == ST_CLEAR, !out_valid_reg && !q_pop)
    `SFPA_ASSERT_NEXT(a_rot_then_conv, state_reg == ST_ROT && iter_reg == LAST_ITER, state_reg == ST_CONV)
    `SFPA_ASSERT_NEXT(a_skip_gives_zero, acc_go && !slot_ok_reg, acc_real_reg == '0 && acc_imag_reg == '0 && !saturated_reg)
    `SFPA_ASSERT_NEXT(a_write_has_result, mem_we && state_reg != ST_CLEAR, out_valid_reg && state_reg == ST_IDLE)

endmodule

/* tb/single_freq_phasor_accumulator_tb.sv */
// Self-checking testbench for the single-frequency phasor accumulator.
// Depends on sfpa_pkg and single_freq_phasor_accumulator; an in-file scoreboard
// predicts each accumulator update and checks the results in order.
`timescale 1ns / 100ps

module single_freq_phasor_accumulator_tb;
    import sfpa_pkg::*;

    localparam int POINTS_N = 512;
    localparam int ANGLE_W  = 10;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    // Arctangent of 2^-i in turns, 2^32 per turn.
    localparam longint ATAN_TURNS [0:15] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic [8:0]         slot;
        logic signed [47:0] re;
        logic signed [47:0] im;
        logic               clip;
    } phasor_result_t;

    class phasor_scoreboard;
        logic [31:0]    phase_step;
        logic [15:0]    dt_scale;
        longint         real_acc [POINTS_N];
        longint         imag_acc [POINTS_N];
        phasor_result_t expected_q [$];
        int             mismatches;

        function new();
            phase_step = PHASE_STEP_RESET;
            dt_scale   = DT_SCALE_RESET;
            foreach (real_acc[i])
            begin
                real_acc[i] = 0;
                imag_acc[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] data);
            case (idx)
                CFG_PHASE_STEP: phase_step = data;
                CFG_DT_SCALE:   dt_scale = data[15:0];
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function longint round_q15(input longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        function void phase_to_cos_sin(input logic [31:0] phase,
                                       output longint c, output longint s);
            logic [31:0] angle;
            longint      x, y, z, dx, dy, xc, yc;
            int          i;
            angle = phase & ~((32'd1 << (32 - ANGLE_W)) - 32'd1);
            z = longint'(angle & 32'h3FFF_FFFF);
            x = 652032874;
            y = 0;
            for (i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURNS[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURNS[i];
                end
            end
            // The top two angle bits rotate the first-quadrant vector.
            case (angle[31:30])
                2'd0:    begin xc = x;  yc = y;  end
                2'd1:    begin xc = -y; yc = x;  end
                2'd2:    begin xc = -x; yc = -y; end
                default: begin xc = y;  yc = -x; end
            endcase
            c = round_q15(xc);
            s = round_q15(yc);
        endfunction

        function longint clip_add(input longint a, input longint b, inout bit clip);
            longint r;
            r = a + b;
            if (r > longint'(ACC_MAX))
            begin
                clip = 1'b1;
                r = longint'(ACC_MAX);
            end
            else if (r < longint'(ACC_MIN))
            begin
                clip = 1'b1;
                r = longint'(ACC_MIN);
            end
            return r;
        endfunction

        function void note_input(input logic [8:0] slot_i, input logic [23:0] step_i,
                                 input logic signed [15:0] sample_i);
            phasor_result_t exp_r;
            logic [31:0]    phase;
            longint         c, s, scaled;
            bit             clip;
            exp_r.slot = slot_i;
            clip = 1'b0;
            // A slot past the array leaves the stores alone and reports zero.
            // With a 9-bit slot and 512 entries this cannot occur here.
            if (slot_i >= POINTS_N)
            begin
                exp_r.re   = '0;
                exp_r.im   = '0;
                exp_r.clip = 1'b0;
            end
            else
            begin
                phase = phase_step * step_i;
                phase_to_cos_sin(phase, c, s);
                scaled = (longint'(sample_i) * longint'(dt_scale)) >>> 16;
                real_acc[slot_i] = clip_add(real_acc[slot_i], scaled * c, clip);
                imag_acc[slot_i] = clip_add(imag_acc[slot_i], -(scaled * s), clip);
                exp_r.re   = real_acc[slot_i][47:0];
                exp_r.im   = imag_acc[slot_i][47:0];
                exp_r.clip = clip;
            end
            expected_q.push_back(exp_r);
        endfunction

        function void check_result(input logic signed [47:0] re, input logic signed [47:0] im,
                                   input logic clip);
            phasor_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending: re %0d im %0d sat %0b",
                                 re, im, clip));
                return;
            end
            exp_r = expected_q.pop_front();
            if (re !== exp_r.re || im !== exp_r.im || clip !== exp_r.clip)
                report($sformatf("slot %0d: re exp %0d got %0d, im exp %0d got %0d, sat exp %0b got %0b",
                                 exp_r.slot, exp_r.re, re, exp_r.im, im, exp_r.clip, clip));
        endfunction

        function void check_leftover();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [8:0]         slot;
    logic [23:0]        step_index;
    logic signed [15:0] field_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [47:0] acc_real;
    logic signed [47:0] acc_imag;
    logic               saturated;

    phasor_scoreboard board;
    int               send_idle_pct;
    int               recv_stall_pct;

    single_freq_phasor_accumulator #(
        .POINTS     (POINTS_N),
        .ANGLE_BITS (ANGLE_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .slot         (slot),
        .step_index   (step_index),
        .field_sample (field_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .acc_real     (acc_real),
        .acc_imag     (acc_imag),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: ready is redrawn at every falling edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(acc_real, acc_imag, saturated);
        end
    end

    // Called at a falling edge; returns at a falling edge with the write strobe dropped again.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input logic [8:0] s, input logic [23:0] n,
                             input logic signed [15:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        slot         = s;
        step_index   = n;
        field_sample = f;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(s, n, f);
        @(negedge clk);
    endtask

    // Holds the input side off until every pending result has been taken.
    task automatic drain();
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int count);
        logic [8:0]         s;
        logic [23:0]        n;
        logic signed [15:0] f;
        int                 k;
        int                 pick;
        s = 9'($urandom_range(511));
        n = 24'($urandom);
        for (k = 0; k < count; k++)
        begin
            // Repeating a slot back to back exercises read-after-write updates of one accumulator entry.
            pick = $urandom_range(99);
            if (pick >= 70)
                s = 9'($urandom_range(511));
            else if (pick >= 30)
                s = 9'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 60)
                n = n + 24'd1;
            else
                n = 24'($urandom);
            pick = $urandom_range(99);
            if (pick < 10)
                f = 16'sh8000;
            else if (pick < 20)
                f = 16'sh7FFF;
            else
                f = 16'($urandom);
            send_item(s, n, f);
        end
    endtask

    initial
    begin
        int          k;
        int          ph;
        int          seg;
        logic [31:0] ps;
        logic [15:0] dt;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PHASE_STEP;
        cfg_data       = '0;
        in_valid       = 1'b0;
        slot           = '0;
        step_index     = '0;
        field_sample   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        board          = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset register values apply until the first write.
        send_item(9'd0, 24'd0, 16'sh7FFF);
        send_item(9'd511, 24'hFF_FFFF, 16'sh8000);
        send_item(9'd0, 24'd5, -16'sd1);
        send_item(9'd1, 24'h80_0000, 16'sd0);
        drain();

        // A quarter turn per step visits all four quadrants.
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(CFG_DT_SCALE, 32'h0000_FFFF);
        for (k = 0; k < 4; k++)
            send_item(9'd2, 24'(k), 16'sh8000);
        for (k = 0; k < 4; k++)
            send_item(9'd3, 24'(k), 16'sh7FFF);
        drain();

        // Writes past the register list must leave both registers unchanged.
        write_reg(CFG_SPARE_A, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_B, 32'h1234_5678);
        send_item(9'd4, 24'd3, 16'sh4000);
        drain();

        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_DT_SCALE, 32'd0);
        send_item(9'd5, 24'hFF_FFFF, 16'sh7FFF);
        send_item(9'd5, 24'd1, 16'sh8000);
        drain();

        // One angle step per time step, up to the last table angle.
        write_reg(CFG_PHASE_STEP, 32'h0040_0000);
        write_reg(CFG_DT_SCALE, 32'h0000_8000);
        send_item(9'd6, 24'd1, 16'sh7FFF);
        send_item(9'd6, 24'd255, 16'sh7FFF);
        send_item(9'd6, 24'd256, 16'sh8000);
        send_item(9'd6, 24'd1023, 16'sh7FFF);
        drain();

        // Clipping needs more than 2^17 full-scale updates of one slot, which is
        // far beyond this run; the scoreboard still models it.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (seg = 0; seg < 2; seg++)
            begin
                drain();
                case (ph * 2 + seg)
                    0:       begin ps = $urandom;       dt = 16'hFFFF; end
                    1:       begin ps = 32'hFFFF_FFFF;  dt = 16'($urandom); end
                    2:       begin ps = 32'd0;          dt = 16'($urandom); end
                    3:       begin ps = {10'($urandom), 22'd0}; dt = 16'($urandom); end
                    4:       begin ps = 32'd1;          dt = 16'hFFFF; end
                    6:       begin ps = 32'h8000_0000;  dt = 16'd1; end
                    default: begin ps = $urandom;       dt = 16'($urandom); end
                endcase
                write_reg(CFG_PHASE_STEP, ps);
                write_reg(CFG_DT_SCALE, {16'd0, dt});
                run_random(85);
            end
        end

        drain();
        repeat (40) @(negedge clk);
        board.check_leftover();
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
